// ===== sv/sth_pkg.sv =====
`default_nettype none
package sth_pkg;

  localparam int CoordBits = 21;
  localparam int SlotW     = 21;
  localparam int DiffW     = 22;
  localparam int ProdW     = 43;
  localparam int DpW       = 45;
  localparam int MagW      = 44;
  localparam int SumW      = 45;
  localparam int CrossW    = 44;
  localparam int SideW     = 66;
  localparam int SideSumW  = 68;
  localparam int QW        = 22;
  localparam int NW        = QW + MagW;
  localparam int RW        = SumW + 1;
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;

  localparam logic [24:0] HitFlag   = 25'h1000000;
  localparam logic [23:0] AttrA400k = 24'h400000;
  localparam logic [23:0] AttrA800k = 24'h800000;
  localparam logic [23:0] Attr8000  = 24'h008000;
  localparam logic [23:0] Attr4000  = 24'h004000;
  localparam logic [23:0] Attr0400  = 24'h000400;
  localparam logic [23:0] Attr0040  = 24'h000040;
  localparam logic [15:0] Flag8000  = 16'h8000;
  localparam logic [15:0] Flag4000  = 16'h4000;
  localparam logic [15:0] Flag2000  = 16'h2000;
  localparam logic [15:0] Flag1000  = 16'h1000;
  localparam logic [15:0] Flag0800  = 16'h0800;
  localparam logic [15:0] Flag0400  = 16'h0400;

  localparam logic RegAltMode = 1'b0;

  typedef struct packed {
    logic [62:0] seg_start;
    logic [62:0] seg_end;
    logic [62:0] corner_a;
    logic [62:0] corner_b;
    logic [62:0] corner_c;
    logic [62:0] face_normal;
    logic [62:0] edge_first;
    logic [62:0] edge_second;
    logic [62:0] edge_third;
    logic [23:0] surface_attr;
    logic [15:0] query_flags;
    logic [23:0] skip_mask;
  } sth_in_t;

  typedef struct packed {
    logic [24:0] hit_code;
    logic [62:0] hit_point;
    logic        crossed;
  } sth_out_t;

  typedef struct packed {
    logic [24:0]                code;
    logic [2:0]                 neg;
    logic [2:0][QW-1:0]         mag;
    logic [2:0][SlotW-1:0]      p1;
  } sth_carry_t;

  typedef struct packed {
    logic [SumW-1:0]            s;
    logic                       crossed;
    logic [24:0]                code;
    logic [2:0]                 neg;
    logic [2:0][SlotW-1:0]      p1;
  } sth_side_t;

  typedef struct packed {
    sth_side_t                  side;
    logic [MagW-1:0]            w1;
    logic [2:0][QW-1:0]         mag;
  } sth_qrec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sth_qstat_t;

  function automatic logic signed [SlotW-1:0] sext_coord(logic [SlotW-1:0] v);
    logic signed [SlotW-1:0] r;
    for (int i = 0; i < SlotW; i++) begin
      r[i] = (i < CoordBits) ? v[i] : v[CoordBits-1];
    end
    return r;
  endfunction

  function automatic logic [SlotW-1:0] slot(logic [62:0] w, int i);
    return w[SlotW*i +: SlotW];
  endfunction

endpackage
`default_nettype wire

// ===== sv/sth_front.sv =====
`default_nettype none
module sth_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 alt_mode_i,
  input  wire logic                 in_valid_i,
  input  wire sth_pkg::sth_in_t     in_data_i,
  output logic                      in_stall_o,
  input  wire sth_pkg::sth_qstat_t  qstat_i,
  output logic                      push_o,
  output sth_pkg::sth_qrec_t        rec_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: differences, filter
  logic signed [2:0][sth_pkg::DiffW-1:0] d0_q, d1_q, seg_q;
  logic signed [2:0][2:0][sth_pkg::DiffW-1:0] b1_q;
  logic signed [2:0][2:0][sth_pkg::SlotW-1:0] e_q;
  logic signed [2:0][sth_pkg::SlotW-1:0] n_q;
  sth_pkg::sth_carry_t c1_q, c2_q, c3_q, c4_q;

  // stage 2: products
  logic signed [2:0][sth_pkg::ProdW-1:0] t0_q, t1_q;
  logic signed [2:0][5:0][sth_pkg::ProdW-1:0] ct_q;
  logic signed [2:0][2:0][sth_pkg::DiffW-1:0] b2_q, b3_q;

  // stage 3: sums
  logic signed [sth_pkg::DpW-1:0] dp0_q, dp1_q;
  logic signed [2:0][2:0][sth_pkg::CrossW-1:0] cr_q;

  // stage 4: side products and weights
  logic signed [2:0][2:0][sth_pkg::SideW-1:0] sp_q;
  logic [sth_pkg::MagW-1:0] w0_q, w1_q;
  logic same_q, dp1nz_q, crossed_q;

  logic signed [2:0][sth_pkg::SlotW-1:0] p0, p1;
  logic signed [2:0][2:0][sth_pkg::SlotW-1:0] cor, ed;
  logic signed [2:0][sth_pkg::SlotW-1:0] nrm;
  logic filt;
  logic [23:0] attr;
  logic [15:0] flg;
  sth_pkg::sth_carry_t c1_d;

  assign en         = !(v4_q && qstat_i.full);
  assign in_stall_o = !en;
  assign attr       = in_data_i.surface_attr;
  assign flg        = in_data_i.query_flags;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i]     = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.seg_start, i));
      p1[i]     = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.seg_end, i));
      cor[0][i] = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.corner_a, i));
      cor[1][i] = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.corner_b, i));
      cor[2][i] = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.corner_c, i));
      ed[0][i]  = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.edge_first, i));
      ed[1][i]  = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.edge_second, i));
      ed[2][i]  = sth_pkg::sext_coord(sth_pkg::slot(in_data_i.edge_third, i));
      nrm[i]    = sth_pkg::slot(in_data_i.face_normal, i);
    end
  end

  always_comb begin
    filt = 1'b0;
    if (!alt_mode_i) begin
      if (((flg & sth_pkg::Flag1000) != '0) && ((attr & sth_pkg::AttrA400k) != '0)) filt = 1'b1;
      if (((flg & sth_pkg::Flag2000) != '0) && ((attr & sth_pkg::Attr4000) != '0))  filt = 1'b1;
      if (((flg & sth_pkg::Flag4000) != '0) && ((attr & sth_pkg::Attr0040) != '0))  filt = 1'b1;
      if (((attr & sth_pkg::Attr0400) != '0) && ((flg & sth_pkg::Flag8000) == '0))  filt = 1'b1;
      if (((flg & sth_pkg::Flag0800) != '0) && ((attr & sth_pkg::Attr8000) != '0))  filt = 1'b1;
      if (((flg & sth_pkg::Flag8000) != '0) && ((attr & sth_pkg::AttrA800k) != '0)) filt = 1'b1;
    end else begin
      if (((flg & sth_pkg::Flag0400) != '0) && ((attr & sth_pkg::Attr4000) != '0))  filt = 1'b1;
      if (((flg & sth_pkg::Flag0800) != '0) && ((attr & sth_pkg::AttrA400k) != '0)) filt = 1'b1;
    end
    if ((in_data_i.skip_mask & attr) != '0) filt = 1'b1;
  end

  always_comb begin
    logic signed [sth_pkg::DiffW-1:0] dl;
    c1_d.code = filt ? 25'd0 : (sth_pkg::HitFlag | {1'b0, attr});
    for (int i = 0; i < 3; i++) begin
      dl           = sth_pkg::DiffW'(signed'(p0[i])) - sth_pkg::DiffW'(signed'(p1[i]));
      c1_d.neg[i]  = dl[sth_pkg::DiffW-1];
      c1_d.mag[i]  = dl[sth_pkg::DiffW-1] ? sth_pkg::QW'(-dl) : sth_pkg::QW'(dl);
      c1_d.p1[i]   = p1[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      n_q  <= nrm;
      e_q  <= ed;
      for (int i = 0; i < 3; i++) begin
        d0_q[i]  <= sth_pkg::DiffW'(signed'(p0[i])) - sth_pkg::DiffW'(signed'(cor[0][i]));
        d1_q[i]  <= sth_pkg::DiffW'(signed'(p1[i])) - sth_pkg::DiffW'(signed'(cor[0][i]));
        seg_q[i] <= sth_pkg::DiffW'(signed'(p1[i])) - sth_pkg::DiffW'(signed'(p0[i]));
        for (int k = 0; k < 3; k++) begin
          b1_q[k][i] <= sth_pkg::DiffW'(signed'(p0[i])) - sth_pkg::DiffW'(signed'(cor[k][i]));
        end
      end
      // stage 2
      b2_q <= b1_q;
      for (int i = 0; i < 3; i++) begin
        t0_q[i] <= sth_pkg::ProdW'(signed'(d0_q[i])) * sth_pkg::ProdW'(signed'(n_q[i]));
        t1_q[i] <= sth_pkg::ProdW'(signed'(d1_q[i])) * sth_pkg::ProdW'(signed'(n_q[i]));
      end
      for (int k = 0; k < 3; k++) begin
        ct_q[k][0] <= sth_pkg::ProdW'(signed'(e_q[k][1])) * sth_pkg::ProdW'(signed'(seg_q[2]));
        ct_q[k][1] <= sth_pkg::ProdW'(signed'(e_q[k][2])) * sth_pkg::ProdW'(signed'(seg_q[1]));
        ct_q[k][2] <= sth_pkg::ProdW'(signed'(e_q[k][2])) * sth_pkg::ProdW'(signed'(seg_q[0]));
        ct_q[k][3] <= sth_pkg::ProdW'(signed'(e_q[k][0])) * sth_pkg::ProdW'(signed'(seg_q[2]));
        ct_q[k][4] <= sth_pkg::ProdW'(signed'(e_q[k][0])) * sth_pkg::ProdW'(signed'(seg_q[1]));
        ct_q[k][5] <= sth_pkg::ProdW'(signed'(e_q[k][1])) * sth_pkg::ProdW'(signed'(seg_q[0]));
      end
      // stage 3
      b3_q  <= b2_q;
      dp0_q <= sth_pkg::DpW'(signed'(t0_q[0])) + sth_pkg::DpW'(signed'(t0_q[1]))
             + sth_pkg::DpW'(signed'(t0_q[2]));
      dp1_q <= sth_pkg::DpW'(signed'(t1_q[0])) + sth_pkg::DpW'(signed'(t1_q[1]))
             + sth_pkg::DpW'(signed'(t1_q[2]));
      for (int k = 0; k < 3; k++) begin
        cr_q[k][0] <= sth_pkg::CrossW'(signed'(ct_q[k][0]))
                    - sth_pkg::CrossW'(signed'(ct_q[k][1]));
        cr_q[k][1] <= sth_pkg::CrossW'(signed'(ct_q[k][2]))
                    - sth_pkg::CrossW'(signed'(ct_q[k][3]));
        cr_q[k][2] <= sth_pkg::CrossW'(signed'(ct_q[k][4]))
                    - sth_pkg::CrossW'(signed'(ct_q[k][5]));
      end
      // stage 4
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          sp_q[k][i] <= sth_pkg::SideW'(signed'(cr_q[k][i]))
                      * sth_pkg::SideW'(signed'(b3_q[k][i]));
        end
      end
      w0_q      <= dp0_q[sth_pkg::DpW-1] ? sth_pkg::MagW'(-dp0_q) : sth_pkg::MagW'(dp0_q);
      w1_q      <= dp1_q[sth_pkg::DpW-1] ? sth_pkg::MagW'(-dp1_q) : sth_pkg::MagW'(dp1_q);
      dp1nz_q   <= (dp1_q != '0);
      same_q    <= ((dp0_q > 0) && (dp1_q > 0)) || ((dp0_q < 0) && (dp1_q < 0));
      crossed_q <= ((dp0_q > 0) && (dp1_q < 0)) || ((dp0_q < 0) && (dp1_q > 0));
    end
  end

  // classify and hand over to the queue
  always_comb begin
    logic signed [sth_pkg::SideSumW-1:0] ss;
    logic side_ok;
    side_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ss = sth_pkg::SideSumW'(signed'(sp_q[k][0])) + sth_pkg::SideSumW'(signed'(sp_q[k][1]))
         + sth_pkg::SideSumW'(signed'(sp_q[k][2]));
      if (ss[sth_pkg::SideSumW-1]) side_ok = 1'b0;
    end
    rec_o.side.s       = sth_pkg::SumW'(w0_q) + sth_pkg::SumW'(w1_q);
    rec_o.side.crossed = crossed_q;
    rec_o.side.code    = (side_ok && !same_q && dp1nz_q) ? c4_q.code : 25'd0;
    rec_o.side.neg     = c4_q.neg;
    rec_o.side.p1      = c4_q.p1;
    rec_o.w1           = w1_q;
    rec_o.mag          = c4_q.mag;
  end

  assign push_o = v4_q && !qstat_i.full;

endmodule
`default_nettype wire

// ===== sv/sth_fifo.sv =====
`default_nettype none
module sth_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sth_pkg::sth_qrec_t  wdata_i,
  input  wire logic                pop_i,
  output sth_pkg::sth_qrec_t       rdata_o,
  output sth_pkg::sth_qstat_t      stat_o
);

  sth_pkg::sth_qrec_t mem_q [sth_pkg::QDepth];
  logic [sth_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [sth_pkg::QPtrW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (sth_pkg::QPtrW+1)'(sth_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sth_back.sv =====
`default_nettype none
module sth_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sth_pkg::sth_qstat_t  qstat_i,
  input  wire sth_pkg::sth_qrec_t   rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  output sth_pkg::sth_out_t         out_data_o,
  input  wire logic                 out_stall_i
);

  localparam int QW = sth_pkg::QW;
  localparam int RW = sth_pkg::RW;

  logic en;
  logic v0_q, out_valid_q;
  sth_pkg::sth_qrec_t rec0_q;
  sth_pkg::sth_out_t  out_q;

  logic                    dv_q   [QW+1];
  sth_pkg::sth_side_t      ds_q   [QW+1];
  logic [2:0][RW-1:0]      dr_q   [QW+1];
  logic [2:0][QW-1:0]      dlo_q  [QW+1];
  logic [2:0][QW-1:0]      dq_q   [QW+1];

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= QW; k++) dv_q[k] <= 1'b0;
    end else if (en) begin
      v0_q        <= pop_o;
      dv_q[0]     <= v0_q;
      for (int k = 0; k < QW; k++) dv_q[k+1] <= dv_q[k];
      out_valid_q <= dv_q[QW];
    end
  end

  // numerator mag*w1; the quotient fits QW bits since w1 <= w0+w1
  always_ff @(posedge clk_i) begin
    logic [sth_pkg::NW-1:0] num;
    if (en) begin
      rec0_q   <= rec_i;
      ds_q[0]  <= rec0_q.side;
      for (int a = 0; a < 3; a++) begin
        num         = sth_pkg::NW'(rec0_q.mag[a]) * sth_pkg::NW'(rec0_q.w1);
        dr_q[0][a]  <= RW'(num[sth_pkg::NW-1:QW]);
        dlo_q[0][a] <= num[QW-1:0];
        dq_q[0][a]  <= '0;
      end
    end
  end

  // one restoring division step per stage and lane
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [RW-1:0] trial;
      logic          ge;
      if (en) begin
        ds_q[k+1]  <= ds_q[k];
        dlo_q[k+1] <= dlo_q[k];
        for (int a = 0; a < 3; a++) begin
          trial = {dr_q[k][a][RW-2:0], dlo_q[k][a][QW-1-k]};
          ge    = (trial >= RW'(ds_q[k].s));
          dr_q[k+1][a] <= ge ? (trial - RW'(ds_q[k].s)) : trial;
          dq_q[k+1][a] <= {dq_q[k][a][QW-2:0], ge};
        end
      end
    end
  end

  // round half away from zero, apply offset to the segment end when crossed
  always_ff @(posedge clk_i) begin
    logic [QW-1:0]           qr;
    logic [sth_pkg::SlotW-1:0] hp;
    if (en) begin
      out_q.hit_code <= ds_q[QW].code;
      out_q.crossed  <= ds_q[QW].crossed;
      for (int a = 0; a < 3; a++) begin
        qr = dq_q[QW][a]
           + QW'({dr_q[QW][a], 1'b0} >= (RW+1)'(ds_q[QW].s));
        if (!ds_q[QW].crossed) begin
          hp = ds_q[QW].p1[a];
        end else if (ds_q[QW].neg[a]) begin
          hp = ds_q[QW].p1[a] - sth_pkg::SlotW'(qr);
        end else begin
          hp = ds_q[QW].p1[a] + sth_pkg::SlotW'(qr);
        end
        out_q.hit_point[sth_pkg::SlotW*a +: sth_pkg::SlotW] <= hp;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/segment_triangle_hit.sv =====
// Path from an input transfer to its result valid: 4 geometry stages (the first loaded
//   at the transfer edge), queue write, queue read, multiply, 22 divide steps, output.
// Throughput: one item per cycle unless a stall holds the flow; the divider is a 22-stage
//   restoring pipeline per axis.
// A 4-entry queue parts the geometry front from the interpolation back.
// Reset clears all valid bits, the queue pointers and the filter mode register.
`default_nettype none
module segment_triangle_hit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire sth_pkg::sth_in_t    in_data_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output sth_pkg::sth_out_t        out_data_o,
  input  wire logic                out_stall_i,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic alt_mode_q;
  logic push, pop;
  sth_pkg::sth_qrec_t  wrec, rrec;
  sth_pkg::sth_qstat_t qstat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sth_pkg::RegAltMode) ? {31'd0, alt_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == sth_pkg::RegAltMode)) begin
      alt_mode_q <= pwdata[0];
    end
  end

  sth_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alt_mode_i (alt_mode_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .qstat_i    (qstat),
    .push_o     (push),
    .rec_o      (wrec)
  );

  sth_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wrec),
    .pop_i   (pop),
    .rdata_o (rrec),
    .stat_o  (qstat)
  );

  sth_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .rec_i       (rrec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

// ===== sv/sth_checker.sv =====
`default_nettype none
module sth_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                out_valid_o,
  input  wire sth_pkg::sth_out_t   out_data_o,
  input  wire logic                out_stall_i,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic [31:0]         prdata,
  input  wire logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped or changed while stalled");

  a_hit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.hit_code == '0) || out_data_o.hit_code[24]))
    else $error("hit code without hit flag");

  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == sth_pkg::RegAltMode))
    |=> ((paddr[2] != sth_pkg::RegAltMode) || (prdata[0] == $past(pwdata[0]))))
    else $error("mode register readback mismatch");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind segment_triangle_hit sth_checker u_sth_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_segment_triangle_hit.sv =====
`default_nettype none
module tb_segment_triangle_hit;

  localparam int LatencyCycles = 40;
  localparam int HoldCycles    = 300;
  localparam int IdlePct       = 38;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  sth_pkg::sth_in_t  in_data = '0;
  logic              in_stall;
  logic              out_valid;
  sth_pkg::sth_out_t out_data;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sth_pkg::sth_in_t  pending_q[$];
  sth_pkg::sth_out_t hit_expect_q[$];
  bit       alt_mode = 1'b0;
  bit       no_idle = 1'b0;
  bit       want_hold = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  int       mismatches = 0;

  segment_triangle_hit DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_data_i(in_data), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_data_o(out_data), .out_stall_i(out_stall),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [62:0] pack_xyz(int x, int y, int z);
    logic [62:0] w;
    w = '0;
    w[20:0]  = x[20:0];
    w[41:21] = y[20:0];
    w[62:42] = z[20:0];
    return w;
  endfunction

  function automatic longint axis(logic [62:0] w, int i);
    logic signed [20:0] s;
    s = w[21*i +: 21];
    return longint'(s);
  endfunction

  function automatic bit attr_filtered(logic [23:0] attr, logic [15:0] flg,
                                       logic [23:0] mask, bit mode);
    bit r;
    r = 1'b0;
    if (!mode) begin
      if ((flg & sth_pkg::Flag1000) != 0 && (attr & sth_pkg::AttrA400k) != 0) r = 1'b1;
      if ((flg & sth_pkg::Flag2000) != 0 && (attr & sth_pkg::Attr4000) != 0) r = 1'b1;
      if ((flg & sth_pkg::Flag4000) != 0 && (attr & sth_pkg::Attr0040) != 0) r = 1'b1;
      if ((attr & sth_pkg::Attr0400) != 0 && (flg & sth_pkg::Flag8000) == 0) r = 1'b1;
      if ((flg & sth_pkg::Flag0800) != 0 && (attr & sth_pkg::Attr8000) != 0) r = 1'b1;
      if ((flg & sth_pkg::Flag8000) != 0 && (attr & sth_pkg::AttrA800k) != 0) r = 1'b1;
    end else begin
      if ((flg & sth_pkg::Flag0400) != 0 && (attr & sth_pkg::Attr4000) != 0) r = 1'b1;
      if ((flg & sth_pkg::Flag0800) != 0 && (attr & sth_pkg::AttrA400k) != 0) r = 1'b1;
    end
    return r || ((mask & attr) != 0);
  endfunction

  function automatic sth_pkg::sth_out_t predict_hit(sth_pkg::sth_in_t x, bit mode);
    sth_pkg::sth_out_t r;
    longint p0[3], p1[3], ca[3], n[3], sg[3], e[3], c[3], cr[3], hp[3];
    logic [62:0] corner[3], edge_v[3];
    longint dp0, dp1, delta;
    logic signed [127:0] side_sum;
    logic [127:0] mag, w0, w1, s, q;
    bit hit, crossed;
    corner[0] = x.corner_a; corner[1] = x.corner_b; corner[2] = x.corner_c;
    edge_v[0] = x.edge_first; edge_v[1] = x.edge_second; edge_v[2] = x.edge_third;
    for (int i = 0; i < 3; i++) begin
      p0[i] = axis(x.seg_start, i);
      p1[i] = axis(x.seg_end, i);
      ca[i] = axis(x.corner_a, i);
      n[i]  = axis(x.face_normal, i);
      sg[i] = p1[i] - p0[i];
    end
    dp0 = (p0[0]-ca[0])*n[0] + (p0[1]-ca[1])*n[1] + (p0[2]-ca[2])*n[2];
    dp1 = (p1[0]-ca[0])*n[0] + (p1[1]-ca[1])*n[1] + (p1[2]-ca[2])*n[2];
    hit = !((dp0 > 0 && dp1 > 0) || (dp0 < 0 && dp1 < 0));
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i]  = axis(edge_v[k], i);
        cr[i] = p0[i] - axis(corner[k], i);
      end
      c[0] = e[1]*sg[2] - e[2]*sg[1];
      c[1] = e[2]*sg[0] - e[0]*sg[2];
      c[2] = e[0]*sg[1] - e[1]*sg[0];
      side_sum = 128'(c[0])*128'(cr[0]) + 128'(c[1])*128'(cr[1]) + 128'(c[2])*128'(cr[2]);
      if (side_sum < 0) hit = 1'b0;
    end
    if (dp1 == 0) hit = 1'b0;
    crossed = (dp0 > 0 && dp1 < 0) || (dp0 < 0 && dp1 > 0);
    w0 = 128'(dp0 < 0 ? -dp0 : dp0);
    w1 = 128'(dp1 < 0 ? -dp1 : dp1);
    s  = w0 + w1;
    for (int i = 0; i < 3; i++) begin
      if (crossed) begin
        delta = p0[i] - p1[i];
        mag = 128'(delta < 0 ? -delta : delta);
        // round half away from zero on the magnitude
        q = (2*mag*w1 + s) / (2*s);
        hp[i] = delta < 0 ? p1[i] - longint'(q) : p1[i] + longint'(q);
      end else begin
        hp[i] = p1[i];
      end
    end
    if (hit && attr_filtered(x.surface_attr, x.query_flags, x.skip_mask, mode)) hit = 1'b0;
    r.hit_code  = hit ? ({1'b0, x.surface_attr} | sth_pkg::HitFlag) : '0;
    r.hit_point = pack_xyz(int'(hp[0]), int'(hp[1]), int'(hp[2]));
    r.crossed   = crossed;
    return r;
  endfunction

  // plane z = 0 triangle hit by a vertical segment; zero edges pass every side test
  function automatic sth_pkg::sth_in_t base_hit();
    sth_pkg::sth_in_t x;
    x = '0;
    x.seg_start   = pack_xyz(10, 10, 40);
    x.seg_end     = pack_xyz(10, 10, -40);
    x.corner_b    = pack_xyz(80, 0, 0);
    x.corner_c    = pack_xyz(0, 80, 0);
    x.face_normal = pack_xyz(0, 0, 1 << 19);
    return x;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [23:0] sparse24();
    return 24'($urandom & $urandom & $urandom);
  endfunction

  function automatic sth_pkg::sth_in_t make_item();
    sth_pkg::sth_in_t x;
    x = '0;
    if ($urandom_range(0, 99) < 20) begin
      x.seg_start = rand63(); x.seg_end = rand63();
      x.corner_a = rand63(); x.corner_b = rand63(); x.corner_c = rand63();
      x.face_normal = rand63(); x.edge_first = rand63();
      x.edge_second = rand63(); x.edge_third = rand63();
      x.surface_attr = 24'($urandom); x.query_flags = 16'($urandom);
      x.skip_mask = 24'($urandom);
    end else begin
      x.corner_a = pack_xyz(small_coord(), small_coord(), small_coord());
      x.corner_b = pack_xyz(small_coord(), small_coord(), small_coord());
      x.corner_c = pack_xyz(small_coord(), small_coord(), small_coord());
      x.seg_start = pack_xyz(small_coord(), small_coord(), small_coord());
      x.seg_end = pack_xyz(small_coord(), small_coord(), small_coord());
      x.face_normal = pack_xyz(int'($urandom_range(0, 1 << 20)) - (1 << 19),
                               int'($urandom_range(0, 1 << 20)) - (1 << 19),
                               int'($urandom_range(0, 1 << 20)) - (1 << 19));
      if ($urandom_range(0, 3) != 0) begin
        x.edge_first  = pack_xyz(small_coord(), small_coord(), small_coord());
        x.edge_second = pack_xyz(small_coord(), small_coord(), small_coord());
        x.edge_third  = pack_xyz(small_coord(), small_coord(), small_coord());
      end
      x.surface_attr = sparse24();
      x.query_flags  = 16'($urandom & $urandom);
      x.skip_mask    = ($urandom_range(0, 3) == 0) ? sparse24() : '0;
    end
    return x;
  endfunction

  task automatic write_mode(bit mode);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * sth_pkg::RegAltMode); pwdata <= {31'b0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    alt_mode = mode;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || hit_expect_q.size() > 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_q.push_back(make_item());
  endtask

  // sender: present the next pending item, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) hit_expect_q.push_back(predict_hit(in_data, alt_mode));
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer, stall at random, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    sth_pkg::sth_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = hit_expect_q.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: code %h/%h point %h/%h crossed %b/%b (exp/act)",
                       want.hit_code, out_data.hit_code, want.hit_point,
                       out_data.hit_point, want.crossed, out_data.crossed);
          end
        end
      end
      if (want_hold && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  initial begin
    sth_pkg::sth_in_t x;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);

    pending_q.push_back('0);                      // segment lying in the plane
    x = '1; pending_q.push_back(x);
    x = '0;
    x.seg_start = {3{21'h0FFFFF}}; x.seg_end = {3{21'h100000}};
    x.corner_a = {3{21'h100000}}; x.face_normal = {3{21'h0FFFFF}};
    x.edge_first = {3{21'h0FFFFF}}; x.edge_second = {3{21'h100000}};
    x.edge_third = {3{21'h0FFFFF}};
    x.surface_attr = 24'hFFFFFF; x.query_flags = 16'hFFFF;
    pending_q.push_back(x);
    x = base_hit(); pending_q.push_back(x);
    x = base_hit(); x.seg_end = pack_xyz(5, 5, 0); pending_q.push_back(x);   // touches at end
    x = base_hit(); x.seg_start = pack_xyz(5, 5, 0); pending_q.push_back(x); // starts on plane
    x = base_hit(); x.seg_end = pack_xyz(10, 10, 7); pending_q.push_back(x); // same side
    x = base_hit(); x.edge_first = pack_xyz(0, 1, 0);                      // side test passes
    x.seg_start = pack_xyz(-10, 10, 40); x.seg_end = pack_xyz(-10, 10, -40);
    pending_q.push_back(x);
    x = base_hit(); x.seg_end = pack_xyz(-31, 77, -13); pending_q.push_back(x); // rounding
    x = base_hit(); x.skip_mask = 24'h000001; x.surface_attr = 24'h000001; pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::Attr0400; pending_q.push_back(x);
    x.query_flags = sth_pkg::Flag8000; pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::AttrA400k; x.query_flags = sth_pkg::Flag1000;
    pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::Attr4000; x.query_flags = sth_pkg::Flag2000;
    pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::Attr0040; x.query_flags = sth_pkg::Flag4000;
    pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::Attr8000; x.query_flags = sth_pkg::Flag0800;
    pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::AttrA800k; x.query_flags = sth_pkg::Flag8000;
    pending_q.push_back(x);
    x = base_hit(); x.surface_attr = sth_pkg::AttrA400k | sth_pkg::Attr4000;
    x.query_flags = sth_pkg::Flag0400 | sth_pkg::Flag0800; pending_q.push_back(x);
    drain();

    write_mode(1'b1);
    pending_q.push_back(x);
    x.query_flags = sth_pkg::Flag0400; pending_q.push_back(x);
    x.query_flags = sth_pkg::Flag0800; pending_q.push_back(x);
    queue_random(500);
    drain();

    write_mode(1'b0);
    no_idle = 1'b1;
    queue_random(150);
    drain();
    no_idle = 1'b0;
    want_hold = 1'b1;
    queue_random(400);
    drain();

    write_mode(1'b1);
    queue_random(200);
    drain();
    write_mode(1'b0);
    queue_random(250);
    drain();

    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ===== segment_triangle_hit.f =====
sv/sth_pkg.sv
sv/sth_front.sv
sv/sth_fifo.sv
sv/sth_back.sv
sv/segment_triangle_hit.sv
sv/sth_checker.sv
tb/sv/tb_segment_triangle_hit.sv
